FILE: rtl/core/adh_pkg.sv
// ----------------------------------------------------------------------------
// adh_pkg
// Types and constants shared by the density profile histogram core.
// ----------------------------------------------------------------------------
package adh_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        MODE_ACCUM = 1'b0,
        MODE_EMIT  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUM_BINS    = 3'd0,
        CFG_AXIS_SELECT = 3'd1,
        CFG_AXIS_LOW    = 3'd2,
        CFG_AXIS_SPAN   = 3'd3,
        CFG_BIN_WIDTH   = 3'd4,
        CFG_INV_SLAB    = 3'd5,
        CFG_TYPE_SELECT = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_CHECK,
        BK_WRITE,
        BK_WALK
    } t_back_state;

    typedef struct packed {
        t_mode              mode;
        logic [7:0]         point_type;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_item;

    typedef struct packed {
        logic [5:0]         bin_number;
        logic signed [39:0] bin_center;
        logic [55:0]        density;
        logic               last_bin;
    } t_result;

    typedef struct packed {
        logic [6:0]         num_bins;
        logic [1:0]         axis_select;
        logic signed [31:0] axis_low;
        logic [30:0]        axis_span;
        logic [30:0]        bin_width;
        logic [31:0]        inv_slab_volume;
        logic [7:0]         type_select;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic        pass;
        logic [31:0] diff;
    } t_qentry;

endpackage

FILE: rtl/core/axis_density_histogram_core.sv
// ----------------------------------------------------------------------------
// axis_density_histogram_core
// One-dimensional density profile histogram along a selectable axis.
// ----------------------------------------------------------------------------
// An accumulate item that hits a bin runs in the back end a queue pop, eight
// divider steps, a count read, a count write; that sets the sustained rate.
// An emit item walks the bins through count read, p1, p2 and output register,
// one per cycle, num_bins results (1..MAX_BINS); counts clear at its end.
// The queue holds two items, so start is taken while the back end works.
// Reset is synchronous: registers return to defaults and all counts read zero.
module axis_density_histogram_core #(
    parameter int MAX_BINS   = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  adh_pkg::t_item                     i_item,
    output logic                               o_result_valid,
    output adh_pkg::t_result                   o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [adh_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [adh_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    adh_pkg::t_cfg    r_cfg;
    adh_pkg::t_qentry front_entry;
    adh_pkg::t_qentry q_entry;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign busy        = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_bins        <= 7'd64;
            r_cfg.axis_select     <= 2'd2;
            r_cfg.axis_low        <= 32'sd0;
            r_cfg.axis_span       <= 31'd4194304;
            r_cfg.bin_width       <= 31'd65536;
            r_cfg.inv_slab_volume <= 32'd0;
            r_cfg.type_select     <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (adh_pkg::t_cfg_reg'(i_cfg_index))
                adh_pkg::CFG_NUM_BINS:    r_cfg.num_bins        <= i_cfg_data[6:0];
                adh_pkg::CFG_AXIS_SELECT: r_cfg.axis_select     <= i_cfg_data[1:0];
                adh_pkg::CFG_AXIS_LOW:    r_cfg.axis_low        <= i_cfg_data;
                adh_pkg::CFG_AXIS_SPAN:   r_cfg.axis_span       <= i_cfg_data[30:0];
                adh_pkg::CFG_BIN_WIDTH:   r_cfg.bin_width       <= i_cfg_data[30:0];
                adh_pkg::CFG_INV_SLAB:    r_cfg.inv_slab_volume <= i_cfg_data;
                adh_pkg::CFG_TYPE_SELECT: r_cfg.type_select     <= i_cfg_data[7:0];
                default:                  r_cfg                 <= r_cfg;
            endcase
        end
    end

    adh_front u_front (
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_entry (front_entry)
    );

    adh_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    adh_back #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_entry),
        .o_q_pop        (q_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

FILE: rtl/core/adh_ram.sv
// ----------------------------------------------------------------------------
// adh_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module adh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/adh_front.sv
// ----------------------------------------------------------------------------
// adh_front
// Classifies an accepted item: picks the profile coordinate, forms its offset
// from the lower bound and applies the type, width and lower-range filters.
// ----------------------------------------------------------------------------
module adh_front (
    input  adh_pkg::t_item   i_item,
    input  adh_pkg::t_cfg    i_cfg,
    output adh_pkg::t_qentry o_entry
);

    logic signed [31:0] coord;
    logic signed [32:0] diff;
    logic               type_ok;

    always_comb begin
        case (adh_pkg::t_axis'(i_cfg.axis_select))
            adh_pkg::AXIS_X: coord = i_item.coord_x;
            adh_pkg::AXIS_Y: coord = i_item.coord_y;
            default:         coord = i_item.coord_z;
        endcase
    end

    assign diff    = 33'(coord) - 33'(i_cfg.axis_low);
    assign type_ok = (i_cfg.type_select == 8'd0) || (i_cfg.type_select == i_item.point_type);

    always_comb begin
        o_entry.mode = i_item.mode;
        o_entry.pass = type_ok && (i_cfg.bin_width != 31'd0) && !diff[32];
        o_entry.diff = diff[31:0];
    end

endmodule

FILE: rtl/core/adh_fifo.sv
// ----------------------------------------------------------------------------
// adh_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module adh_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  adh_pkg::t_qentry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output adh_pkg::t_qentry o_entry
);

    localparam int PTR_W = $clog2(adh_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(adh_pkg::QUEUE_DEPTH + 1);

    adh_pkg::t_qentry r_entries [adh_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == adh_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == adh_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = (32'(r_count) == adh_pkg::QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_entry = r_entries[r_rd_ptr];

endmodule

FILE: rtl/core/adh_back.sv
// ----------------------------------------------------------------------------
// adh_back
// Executes queued items: a restoring divider finds the bin of a point and a
// read-modify-write bumps its count; an emit walks the bins through a short
// pipeline that forms center and density, then clears all counts.
// ----------------------------------------------------------------------------
module adh_back #(
    parameter int MAX_BINS   = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  adh_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  adh_pkg::t_qentry i_q_entry,
    output logic             o_q_pop,
    output logic             o_result_valid,
    output adh_pkg::t_result o_result
);

    localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int PROD_W = COUNT_BITS + 32;
    localparam logic [2:0] DIV_TOP = 3'd7;

    adh_pkg::t_back_state r_state, n_state;

    logic [31:0]           r_rem;
    logic [31:0]           r_diff;
    logic [37:0]           r_dsh;
    logic [2:0]            r_step;
    logic [6:0]            r_quot;
    logic [ADDR_W-1:0]     r_addr;
    logic [ADDR_W-1:0]     r_idx;
    logic signed [40:0]    r_center2;
    logic [MAX_BINS-1:0]   r_valid;

    logic                  r_p1_vld;
    logic [ADDR_W-1:0]     r_p1_idx;
    logic signed [40:0]    r_p1_center2;
    logic                  r_p1_last;

    logic                  r_p2_vld;
    logic [ADDR_W-1:0]     r_p2_idx;
    logic signed [40:0]    r_p2_center2;
    logic                  r_p2_last;
    logic [PROD_W-1:0]     r_p2_prod;

    logic                  r_out_vld;
    adh_pkg::t_result      r_out;

    logic [6:0]            bins_used;
    logic                  rem_ge;
    logic [6:0]            q_fin;
    logic                  hit;
    logic                  walk_last;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] walk_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic [PROD_W-1:0]     prod;
    logic [63:0]           prod64;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;

    always_comb begin
        if (i_cfg.num_bins == 7'd0) begin
            bins_used = 7'd1;
        end else if (i_cfg.num_bins > 7'(MAX_BINS)) begin
            bins_used = 7'(MAX_BINS);
        end else begin
            bins_used = i_cfg.num_bins;
        end
    end

    assign rem_ge = {6'd0, r_rem} >= r_dsh;

    always_comb begin
        q_fin = r_quot;
        if ((r_quot == bins_used) && ({1'b0, r_diff} <= {2'b00, i_cfg.axis_span})) begin
            q_fin = bins_used - 7'd1;
        end
    end

    assign hit       = q_fin < bins_used;
    assign walk_last = (7'(r_idx) == (bins_used - 7'd1));

    assign cur_cnt  = r_valid[r_addr] ? rd_data : '0;
    assign inc_cnt  = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
    assign walk_cnt = r_valid[r_p1_idx] ? rd_data : '0;
    assign prod     = PROD_W'(walk_cnt) * PROD_W'(i_cfg.inv_slab_volume);
    assign prod64   = 64'(r_p2_prod);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            adh_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_entry.mode == adh_pkg::MODE_EMIT) begin
                        n_state = adh_pkg::BK_WALK;
                    end else if (i_q_entry.pass) begin
                        n_state = adh_pkg::BK_DIV;
                    end
                end
            end
            adh_pkg::BK_DIV: begin
                if ((r_step == DIV_TOP) && rem_ge) begin
                    n_state = adh_pkg::BK_IDLE;
                end else if (r_step == 3'd0) begin
                    n_state = adh_pkg::BK_CHECK;
                end
            end
            adh_pkg::BK_CHECK: begin
                n_state = hit ? adh_pkg::BK_WRITE : adh_pkg::BK_IDLE;
            end
            adh_pkg::BK_WRITE: begin
                n_state = adh_pkg::BK_IDLE;
            end
            adh_pkg::BK_WALK: begin
                if (walk_last) begin
                    n_state = adh_pkg::BK_IDLE;
                end
            end
            default: n_state = adh_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        unique case (r_state)
            adh_pkg::BK_IDLE:  o_q_pop = i_q_valid;
            adh_pkg::BK_DIV:   rd_en = 1'b0;
            adh_pkg::BK_CHECK: begin
                rd_en   = hit;
                rd_addr = q_fin[ADDR_W-1:0];
            end
            adh_pkg::BK_WRITE: wr_en = 1'b1;
            adh_pkg::BK_WALK:  rd_en = 1'b1;
            default:           rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= adh_pkg::BK_IDLE;
            r_valid   <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p1_vld  <= (r_state == adh_pkg::BK_WALK);
            r_p2_vld  <= r_p1_vld;
            r_out_vld <= r_p2_vld;
            if (r_p1_vld && r_p1_last) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            adh_pkg::BK_IDLE: begin
                r_rem     <= i_q_entry.diff;
                r_diff    <= i_q_entry.diff;
                r_dsh     <= {i_cfg.bin_width, 7'd0};
                r_step    <= DIV_TOP;
                r_quot    <= '0;
                r_idx     <= '0;
                r_center2 <= {{8{i_cfg.axis_low[31]}}, i_cfg.axis_low, 1'b0}
                             + 41'(i_cfg.bin_width);
            end
            adh_pkg::BK_DIV: begin
                if (r_step != DIV_TOP) begin
                    if (rem_ge) begin
                        r_rem <= r_rem - r_dsh[31:0];
                    end
                    r_quot <= {r_quot[5:0], rem_ge};
                end
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step - 3'd1;
            end
            adh_pkg::BK_CHECK: begin
                r_addr <= q_fin[ADDR_W-1:0];
            end
            adh_pkg::BK_WALK: begin
                r_idx     <= r_idx + 1'b1;
                r_center2 <= r_center2 + {9'd0, i_cfg.bin_width, 1'b0};
            end
            default: begin
                r_addr <= r_addr;
            end
        endcase

        r_p1_idx     <= r_idx;
        r_p1_center2 <= r_center2;
        r_p1_last    <= walk_last;

        r_p2_idx     <= r_p1_idx;
        r_p2_center2 <= r_p1_center2;
        r_p2_last    <= r_p1_last;
        r_p2_prod    <= prod;

        r_out.bin_number <= 6'(r_p2_idx);
        r_out.bin_center <= r_p2_center2[40:1];
        r_out.density    <= (|prod64[63:56]) ? '1 : prod64[55:0];
        r_out.last_bin   <= r_p2_last;
    end

    adh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_BINS)
    ) u_counts (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (inc_cnt),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

endmodule

FILE: rtl/core/adh_checker.sv
// ----------------------------------------------------------------------------
// adh_checker
// Port-level checks on the result stream of the histogram core.
// ----------------------------------------------------------------------------
module adh_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             busy,
    input logic             o_result_valid,
    input adh_pkg::t_result o_result
);

    // A profile streams out with no gaps and ascending bin numbers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.last_bin |=>
            o_result_valid && (o_result.bin_number == 6'($past(o_result.bin_number) + 6'd1)))
        else $error("profile transfer broke its bin sequence");

    // Each profile starts at bin zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !$past(o_result_valid) |-> (o_result.bin_number == 6'd0))
        else $error("profile did not start at bin zero");

    // The last bin of a profile is followed by at least one idle cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last_bin |=> !o_result_valid)
        else $error("transfer directly after the last bin");

    // Reset leaves no result pending and the input side open.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid && !busy)
        else $error("result or busy seen right after reset");

endmodule

bind axis_density_histogram_core adh_checker u_adh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
